>>> rtl/lsrw_pkg.sv
// Shared types, codes and the lane mapping function for the LCD shift register writer.
// Depends on nothing; all files but the checker refer to it by scoped names.
`timescale 1ns / 1ps

package lsrw_pkg;

  // Request operation codes
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_NIBBLE = 2'd1;
  localparam logic [1:0] FUNC_STROBE = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FOUR_BIT = 1'b0;
  localparam logic CFG_LANES    = 1'b1;

  localparam logic [23:0] LANES_RESET = 24'hFAC688;

  // Positions of the pins in the pin level vector
  localparam int PIN_CLK = 0;
  localparam int PIN_DAT = 1;
  localparam int PIN_RS  = 2;
  localparam int PIN_EN  = 3;

  // Step numbers within one transfer
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_FIRST    = 5'd0;
  localparam logic [STEP_W-1:0] STEP_CLK_LOW  = 5'd16;
  localparam logic [STEP_W-1:0] STEP_RS       = 5'd17;
  localparam logic [STEP_W-1:0] STEP_EN_HIGH  = 5'd18;
  localparam logic [STEP_W-1:0] STEP_LAST     = 5'd19;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic [7:0] sr_hi;
    logic [7:0] sr_lo;
    logic       two_xfer;
    logic       strobe_only;
    logic       rs;
  } cmd_t;

  // Place each set bit k on the shift register bit given by lane field k.
  function automatic logic [7:0] map_lanes(logic [7:0] bits, logic [23:0] lanes);
    logic [7:0] m;
    logic [2:0] pos;
    m = '0;
    for (int k = 0; k < 8; k++) begin
      pos = lanes[3*k +: 3];
      if (bits[k]) m[pos] = 1'b1;
    end
    return m;
  endfunction

endpackage

>>> rtl/lsrw_front.sv
// Front end: holds the configuration registers, classifies requests and maps bytes to lanes.
// Depends on lsrw_pkg.
`timescale 1ns / 1ps

module lsrw_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [23:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        func,
  input  logic [7:0]        data_byte,
  input  logic              reg_select,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output lsrw_pkg::cmd_t    cmd
);

  logic        four_bit_mode;
  logic [23:0] lane_positions;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode  <= 1'b1;
      lane_positions <= lsrw_pkg::LANES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsrw_pkg::CFG_FOUR_BIT: four_bit_mode  <= cfg_data[0];
        lsrw_pkg::CFG_LANES:    lane_positions <= cfg_data;
      endcase
    end
  end

  logic [7:0] hi_nib_map, lo_nib_map, byte_map;

  assign hi_nib_map = lsrw_pkg::map_lanes({data_byte[7:4], 4'b0000}, lane_positions);
  assign lo_nib_map = lsrw_pkg::map_lanes({data_byte[3:0], 4'b0000}, lane_positions);
  assign byte_map   = lsrw_pkg::map_lanes(data_byte, lane_positions);

  always_comb begin
    cmd.sr_hi       = hi_nib_map;
    cmd.sr_lo       = lo_nib_map;
    cmd.two_xfer    = 1'b0;
    cmd.strobe_only = 1'b0;
    cmd.rs          = reg_select;
    unique case (func)
      lsrw_pkg::FUNC_WRITE: begin
        cmd.two_xfer = four_bit_mode;
        if (!four_bit_mode) cmd.sr_hi = byte_map;
      end
      lsrw_pkg::FUNC_NIBBLE: begin
      end
      lsrw_pkg::FUNC_STROBE: begin
        cmd.strobe_only = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The unused code is accepted and dropped without reaching the queue.
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid && (func != lsrw_pkg::FUNC_NONE);

endmodule

>>> rtl/lsrw_queue.sv
// Short command queue between the front end and the pin sequencer.
// Depends on lsrw_pkg.
`timescale 1ns / 1ps

module lsrw_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  lsrw_pkg::cmd_t    wr_cmd,
  output logic              rd_valid,
  input  logic              rd_pop,
  output lsrw_pkg::cmd_t    rd_cmd
);

  lsrw_pkg::cmd_t entries [lsrw_pkg::QDEPTH];
  logic [lsrw_pkg::QAW-1:0] wr_ptr, rd_ptr;
  logic [lsrw_pkg::QCW-1:0] count;
  logic push, pop;

  assign wr_ready = (count != lsrw_pkg::QCW'(lsrw_pkg::QDEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;
  assign rd_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> rtl/lsrw_back.sv
// Back end: registers shift register and LCD pin levels, one change per cycle unless stalled.
// Depends on lsrw_pkg.
`timescale 1ns / 1ps

module lsrw_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  lsrw_pkg::cmd_t    q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              shift_clock,
  output logic              shift_data,
  output logic              rs_pin,
  output logic              enable_pin,
  output logic              last
);

  lsrw_pkg::cmd_t cur;
  logic                        busy;
  logic                        second;
  logic [lsrw_pkg::STEP_W-1:0] step;
  logic [3:0]                  pins;
  logic [3:0]                  pins_next;
  logic [7:0]                  sr;
  logic                        adv, emit, end_xfer, last_step;

  assign sr        = second ? cur.sr_lo : cur.sr_hi;
  assign adv       = !out_valid || out_ready;
  assign emit      = busy && adv;
  assign end_xfer  = (step == lsrw_pkg::STEP_LAST);
  assign last_step = end_xfer && (!cur.two_xfer || second);
  assign q_pop     = q_valid && (!busy || (emit && last_step));

  always_comb begin
    pins_next = pins;
    priority if (step < lsrw_pkg::STEP_CLK_LOW) begin
      // Even steps present a data bit with the clock low, odd steps raise the clock.
      if (!step[0]) begin
        pins_next[lsrw_pkg::PIN_CLK] = 1'b0;
        pins_next[lsrw_pkg::PIN_DAT] = sr[~step[3:1]];
      end else begin
        pins_next[lsrw_pkg::PIN_CLK] = 1'b1;
      end
    end else if (step == lsrw_pkg::STEP_CLK_LOW) begin
      pins_next[lsrw_pkg::PIN_CLK] = 1'b0;
    end else if (step == lsrw_pkg::STEP_RS) begin
      pins_next[lsrw_pkg::PIN_RS] = cur.rs;
    end else if (step == lsrw_pkg::STEP_EN_HIGH) begin
      pins_next[lsrw_pkg::PIN_EN] = 1'b1;
    end else begin
      pins_next[lsrw_pkg::PIN_EN] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_cmd;
    if (emit) begin
      shift_clock <= pins_next[lsrw_pkg::PIN_CLK];
      shift_data  <= pins_next[lsrw_pkg::PIN_DAT];
      rs_pin      <= pins_next[lsrw_pkg::PIN_RS];
      enable_pin  <= pins_next[lsrw_pkg::PIN_EN];
      last        <= last_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      second    <= 1'b0;
      step      <= lsrw_pkg::STEP_FIRST;
      pins      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        pins      <= pins_next;
        out_valid <= 1'b1;
        if (end_xfer) begin
          if (!last_step) begin
            second <= 1'b1;
            step   <= lsrw_pkg::STEP_FIRST;
          end else begin
            busy <= 1'b0;
          end
        end else begin
          step <= step + 1'b1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // Loading the next command takes precedence over going idle.
      if (q_pop) begin
        busy   <= 1'b1;
        second <= 1'b0;
        step   <= q_cmd.strobe_only ? lsrw_pkg::STEP_RS : lsrw_pkg::STEP_FIRST;
      end
    end
  end

endmodule

>>> rtl/lcd_shift_register_writer.sv
// LCD writer over a serial shift register: one pin step per cycle when the output is taken.
// A full byte in four-bit mode gives 40 steps, in eight-bit mode or a high nibble 20, a strobe 3.
// A request is registered in the queue and in the sequencer before its first step is output;
// the sequencer sets the throughput; the two-entry queue takes requests while earlier ones step.
// Synchronous active-high reset: output invalid, four-bit mode on, identity lanes, queue empty.
// Depends on lsrw_pkg, lsrw_front, lsrw_queue and lsrw_back.
`timescale 1ns / 1ps

module lcd_shift_register_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  data_byte,
  input  logic        reg_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        shift_clock,
  output logic        shift_data,
  output logic        rs_pin,
  output logic        enable_pin,
  output logic        last
);

  lsrw_pkg::cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_pop;

  lsrw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .data_byte  (data_byte),
    .reg_select (reg_select),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  lsrw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (q_cmd)
  );

  lsrw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_cmd       (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shift_clock (shift_clock),
    .shift_data  (shift_data),
    .rs_pin      (rs_pin),
    .enable_pin  (enable_pin),
    .last        (last)
  );

endmodule

>>> rtl/lsrw_checker.sv
// Port-level checks for the LCD shift register writer, bound to the top level.
// Depends on lcd_shift_register_writer ports only.
`timescale 1ns / 1ps

module lsrw_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic shift_clock,
  input logic shift_data,
  input logic rs_pin,
  input logic enable_pin,
  input logic last
);

  // A stalled result holds its pin levels.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({shift_clock, shift_data, rs_pin, enable_pin, last}))
    else $error("stalled pin step changed");

  // Enable is only ever pulsed with the shift clock low.
  a_en_clk: assert property (@(posedge clk) disable iff (rst)
    out_valid && enable_pin |-> !shift_clock)
    else $error("enable high with shift clock high");

  // Every queued request ends with enable dropped and the clock low.
  a_last_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !enable_pin && !shift_clock)
    else $error("final step leaves enable or clock high");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lcd_shift_register_writer lsrw_checker u_lsrw_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .shift_clock (shift_clock),
  .shift_data  (shift_data),
  .rs_pin      (rs_pin),
  .enable_pin  (enable_pin),
  .last        (last)
);
